// ===== hw/rtl/tmcs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmcs_pkg
// Types, codes and constants shared by the membership and clock sync block.
// ----------------------------------------------------------------------------
package tmcs_pkg;

  localparam int MAX_CHILDREN_DEF = 8;
  localparam int CFG_W            = 20;
  localparam int CFG_IDX_W        = 3;
  localparam int DVD_W            = 40;
  localparam int DEN_W            = 20;

  localparam logic [19:0] PERIOD_RST  = 20'd640;
  localparam logic [19:0] GUARD_RST   = 20'd192;
  localparam logic [19:0] DEAD_RST    = 20'd6400;
  localparam logic [19:0] SLOT_RST    = 20'd128;
  localparam logic [19:0] LEAD_RST    = 20'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD = 3'd0,
    REG_GUARD  = 3'd1,
    REG_DEAD   = 3'd2,
    REG_SLOT   = 3'd3,
    REG_LEAD   = 3'd4
  } reg_idx_t;

  localparam logic [1:0] OP_PKT    = 2'd0;
  localparam logic [1:0] OP_BEACON = 2'd1;
  localparam logic [1:0] OP_ROUND  = 2'd2;

  localparam logic [1:0] KIND_COORD = 2'd1;
  localparam logic [1:0] MSG_DISC   = 2'd0;
  localparam logic [1:0] MSG_COUNT  = 2'd1;
  localparam logic [1:0] MSG_SYNC   = 2'd2;

  localparam logic [1:0] RES_BEACON = 2'd0;
  localparam logic [1:0] RES_ASSIGN = 2'd1;
  localparam logic [1:0] RES_REPORT = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] now;
    logic        well_formed;
    logic [1:0]  sender_kind;
    logic [1:0]  msg_kind;
    logic [11:0] payload;
    logic [31:0] reported_clock;
    logic [63:0] src_addr;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [63:0] child_addr;
    logic [2:0]  slot_index;
    logic [19:0] slot_duration;
    logic [31:0] clock_value;
    logic [7:0]  message_count;
    logic [31:0] next_wait;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic idle;
    logic latch;
    logic pkt;
    logic beacon;
    logic sum_clr;
    logic sum_step;
    logic div_avg;
    logic apply;
    logic div_mod;
    logic store_rem;
    logic emit_assign;
    logic emit_report;
    logic rm_shift;
    logic idx_inc;
    logic idx_clr;
  } cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] opcode;
    logic       idx_lt_cnt;
    logic       dead;
    logic       div_done;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tmcs_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmcs_in_if / tmcs_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface tmcs_in_if;
  import tmcs_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tmcs_out_if;
  import tmcs_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tdma_membership_clock_sync.sv =====
`default_nettype none
// Packet: latched when idle, applied in the packet state; beacon: waits for a free output.
// Round end: a summing walk, an averaging and a modulo divider pass of 40 steps each
// (each waited on for done), assignments and report, then a removal walk, plus stalls.
// One transaction in flight; the next is accepted when the sequencer is idle.
// Synchronous active-high reset clears the table count, clocks and registers.
// ----------------------------------------------------------------------------
// tdma_membership_clock_sync
// Border-node child table with slot assignment and network clock averaging.
// ----------------------------------------------------------------------------
module tdma_membership_clock_sync
  import tmcs_pkg::*;
#(
  parameter int MAX_CHILDREN = MAX_CHILDREN_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  tmcs_in_if.sink                   in_ch,
  tmcs_out_if.source                out_ch
);
  cmd_t cmd;
  sts_t sts;

  tmcs_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  tmcs_dp #(.MAX_CHILDREN(MAX_CHILDREN)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );
endmodule
`default_nettype wire

// ===== hw/rtl/tmcs_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmcs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tmcs_div
  import tmcs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic                  done,
  output logic [DVD_W-1:0]      quot,
  output logic [DEN_W-1:0]      rem
);
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   trial;

  assign trial = {rem, quot[DVD_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
        quot <= dividend;
        den  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          rem  <= DEN_W'(trial - {1'b0, den});
          quot <= {quot[DVD_W-2:0], 1'b1};
        end else begin
          rem  <= trial[DEN_W-1:0];
          quot <= {quot[DVD_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/tmcs_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmcs_ctrl
// Sequencer for packet, beacon and round-end transactions.
// ----------------------------------------------------------------------------
module tmcs_ctrl
  import tmcs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_PKT    = 10'b0000000010,
    S_BEACON = 10'b0000000100,
    S_SUM    = 10'b0000001000,
    S_WAITA  = 10'b0000010000,
    S_MODS   = 10'b0000100000,
    S_WAITM  = 10'b0001000000,
    S_EMIT   = 10'b0010000000,
    S_REMOVE = 10'b0100000000,
    S_SPARE  = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (sts.in_valid) begin
          cmd.latch   = 1'b1;
          cmd.sum_clr = 1'b1;
          cmd.idx_clr = 1'b1;
          case (sts.opcode)
            OP_PKT:    state_next = S_PKT;
            OP_BEACON: state_next = S_BEACON;
            OP_ROUND:  state_next = S_SUM;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_PKT: begin
        cmd.pkt = 1'b1;
        state_next = S_IDLE;
      end
      S_BEACON: begin
        if (sts.out_free) begin
          cmd.beacon = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SUM: begin
        if (sts.idx_lt_cnt) begin
          cmd.sum_step = 1'b1;
          cmd.idx_inc  = 1'b1;
        end else begin
          cmd.div_avg = 1'b1;
          state_next = S_WAITA;
        end
      end
      S_WAITA: begin
        if (sts.div_done) begin
          cmd.apply = 1'b1;
          state_next = S_MODS;
        end
      end
      S_MODS: begin
        cmd.div_mod = 1'b1;
        state_next = S_WAITM;
      end
      S_WAITM: begin
        if (sts.div_done) begin
          cmd.store_rem = 1'b1;
          cmd.idx_clr   = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          if (sts.idx_lt_cnt) begin
            cmd.emit_assign = 1'b1;
            cmd.idx_inc     = 1'b1;
          end else begin
            cmd.emit_report = 1'b1;
            cmd.idx_clr     = 1'b1;
            state_next = S_REMOVE;
          end
        end
      end
      S_REMOVE: begin
        if (sts.idx_lt_cnt) begin
          if (sts.dead) cmd.rm_shift = 1'b1;
          else cmd.idx_inc = 1'b1;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/tmcs_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmcs_dp
// Child table, configuration, clock averaging and result register.
// ----------------------------------------------------------------------------
module tmcs_dp
  import tmcs_pkg::*;
#(
  parameter int MAX_CHILDREN = MAX_CHILDREN_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire cmd_t                 cmd,
  output sts_t                      sts,
  tmcs_in_if.sink                   in_ch,
  tmcs_out_if.source                out_ch
);
  localparam int CW   = $clog2(MAX_CHILDREN + 1);
  localparam int IW   = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;
  localparam int SW   = 32 + CW + 1;

  logic [19:0] period, guard, dead_to, lead;

  in_item_t    it;
  logic [63:0] addr [MAX_CHILDREN];
  logic [31:0] rclk [MAX_CHILDREN];
  logic [31:0] lh   [MAX_CHILDREN];
  logic [CW-1:0] count, idx;
  logic [19:0] slot;
  logic [31:0] net, beacon_t;
  logic [7:0]  round_cnt;
  logic signed [SW-1:0] sum;
  logic [CW:0] rcnt;
  logic [19:0] rem_r;
  logic        sum_neg;

  logic        out_valid;
  out_item_t   out_data;
  out_item_t   out_next;
  logic        out_load;

  logic             div_start, div_done;
  logic [DVD_W-1:0] div_dvd, div_q;
  logic [DEN_W-1:0] div_den, div_r;
  logic [19:0]      per;

  logic [IW-1:0] ix;
  logic [31:0]   diff;
  logic [MAX_CHILDREN-1:0] match, first;
  logic [25:0]   prod;
  logic          overrun, coord, disc_ok;
  logic [31:0]   avg;
  logic [SW-1:0] sum_abs;
  logic [22:0]   wait_t;
  logic [31:0]   wait_v;

  assign ix     = idx[IW-1:0];
  assign per    = (period == 20'd0) ? 20'd1 : period;
  assign diff   = rclk[ix] - net;
  assign coord  = it.sender_kind == KIND_COORD;
  assign disc_ok = it.well_formed && coord && it.msg_kind == MSG_DISC
                   && count < CW'(MAX_CHILDREN);
  assign prod   = 26'({1'b0, count} + 1'b1) * 26'(slot);
  assign overrun = ({1'b0, prod} + 27'(guard)) > 27'(period);

  always_comb begin
    for (int j = 0; j < MAX_CHILDREN; j++) begin
      match[j] = (CW'(j) < count) && (addr[j] == it.src_addr);
    end
    first = match & ~(match - 1'b1);
  end

  assign sum_abs = sum[SW-1] ? SW'(-sum) : SW'(sum);
  assign avg     = sum_neg ? 32'(-div_q) : div_q[31:0];
  assign wait_t  = {2'b0, per, 1'b0} - {3'b0, lead} - {3'b0, rem_r};
  assign wait_v  = wait_t[22] ? 32'd0 : 32'(wait_t);

  assign div_start = cmd.div_avg || cmd.div_mod;
  assign div_dvd   = cmd.div_avg ? DVD_W'(sum_abs) : DVD_W'(net);
  assign div_den   = cmd.div_avg ? DEN_W'(rcnt) : per;

  tmcs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_den),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      period  <= PERIOD_RST;
      guard   <= GUARD_RST;
      dead_to <= DEAD_RST;
      lead    <= LEAD_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PERIOD: period  <= cfg_data;
        REG_GUARD:  guard   <= cfg_data;
        REG_DEAD:   dead_to <= cfg_data;
        REG_LEAD:   lead    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) it <= in_ch.data;
    if (cmd.store_rem) rem_r <= div_r;
    if (cmd.div_avg) sum_neg <= sum[SW-1];
    if (cmd.pkt) begin
      for (int j = 0; j < MAX_CHILDREN; j++) begin
        if (it.well_formed && first[j]) lh[j] <= it.now;
      end
      if (disc_ok) begin
        addr[count[IW-1:0]] <= it.src_addr;
        lh[count[IW-1:0]]   <= it.now;
      end
    end
    if (cmd.rm_shift) begin
      for (int j = 0; j < MAX_CHILDREN - 1; j++) begin
        if (CW'(j) >= idx) begin
          addr[j] <= addr[j+1];
          lh[j]   <= lh[j+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < MAX_CHILDREN; j++) rclk[j] <= '0;
      count     <= '0;
      idx       <= '0;
      slot      <= SLOT_RST;
      net       <= '0;
      beacon_t  <= '0;
      round_cnt <= '0;
      sum       <= '0;
      rcnt      <= '0;
    end else begin
      if (cmd.idx_clr) idx <= '0;
      else if (cmd.idx_inc) idx <= idx + 1'b1;
      if (cmd.sum_clr) begin
        sum  <= '0;
        rcnt <= (CW+1)'(1);
      end else if (cmd.sum_step && rclk[ix] != 32'd0) begin
        sum  <= sum + SW'($signed(diff));
        rcnt <= rcnt + 1'b1;
      end
      if (cmd.beacon) beacon_t <= it.now;
      if (cmd.pkt && it.well_formed && coord) begin
        if (disc_ok) begin
          if (overrun) slot <= {1'b0, slot[19:1]};
          rclk[count[IW-1:0]] <= '0;
          count <= count + 1'b1;
        end
        if (it.msg_kind == MSG_COUNT) round_cnt <= round_cnt + it.payload[7:0];
        if (it.msg_kind == MSG_SYNC) begin
          for (int j = 0; j < MAX_CHILDREN; j++) begin
            if (match[j]) rclk[j] <= it.reported_clock;
          end
        end
      end
      if (cmd.apply) begin
        net <= net + avg + (it.now - beacon_t);
        for (int j = 0; j < MAX_CHILDREN; j++) rclk[j] <= '0;
      end
      if (cmd.emit_report) round_cnt <= '0;
      if (cmd.rm_shift) begin
        for (int j = 0; j < MAX_CHILDREN - 1; j++) begin
          if (CW'(j) >= idx) rclk[j] <= rclk[j+1];
        end
        rclk[MAX_CHILDREN-1] <= '0;
        count <= count - 1'b1;
      end
    end
  end

  assign out_load = cmd.beacon || cmd.emit_assign || cmd.emit_report;

  always_comb begin
    out_next               = '0;
    out_next.slot_duration = slot;
    out_next.clock_value   = net;
    if (cmd.beacon) begin
      out_next.result_kind = RES_BEACON;
      out_next.clock_value = 32'(slot);
      out_next.last        = 1'b1;
    end else if (cmd.emit_assign) begin
      out_next.result_kind = RES_ASSIGN;
      out_next.child_addr  = addr[ix];
      out_next.slot_index  = 3'(idx);
    end else begin
      out_next.result_kind   = RES_REPORT;
      out_next.message_count = round_cnt;
      out_next.next_wait     = wait_v;
      out_next.last          = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data <= out_next;
  end

  assign in_ch.ready = cmd.idle && !rst;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  assign sts.in_valid   = in_ch.valid;
  assign sts.opcode     = in_ch.data.opcode;
  assign sts.idx_lt_cnt = idx < count;
  assign sts.dead       = (it.now - lh[ix]) > {12'd0, dead_to};
  assign sts.div_done   = div_done;
  assign sts.out_free   = !out_valid || out_ch.ready;

`ifndef NO_ASSERTIONS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_CHILDREN)) else $error("child count above table size");
  a_clocks_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |=> rclk[0] == 32'd0) else $error("reported clock not cleared");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    cmd.rm_shift |=> count + 1'b1 == $past(count)) else $error("bad removal");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_assign || cmd.emit_report || cmd.beacon) |-> sts.out_free)
    else $error("result overwritten");
`endif
endmodule
`default_nettype wire
